>>> rtl/core/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Shared widths, mode codes, status codes and register indexes of the
// chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int ENTRY_BITS_DEF    = 16;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TAKE  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHAIN_ERR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DIRTY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FREE_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE = 1'd1;

    localparam logic [CFG_DAT_W-1:0] FREE_CODE_RST = 16'h0000;
    localparam logic [CFG_DAT_W-1:0] LAST_CODE_RST = 16'hFFFF;

endpackage

>>> rtl/core/fca_if.sv
// ----------------------------------------------------------------------------
// fca_if
// Request, response and configuration channels of the chain allocator.
// ----------------------------------------------------------------------------
interface fca_req_if;
    logic                        valid;
    logic                        ready;
    logic [fca_pkg::MODE_W-1:0]  mode;
    logic [fca_pkg::INDEX_W-1:0] entry_index;
    logic [fca_pkg::VALUE_W-1:0] entry_value;

    modport source (output valid, mode, entry_index, entry_value, input ready);
    modport sink   (input valid, mode, entry_index, entry_value, output ready);
endinterface

interface fca_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fca_pkg::VALUE_W-1:0]  out_value;
    logic [fca_pkg::INDEX_W-1:0]  out_index;
    logic [fca_pkg::STATUS_W-1:0] status;

    modport source (output valid, out_value, out_index, status, input ready);
    modport sink   (input valid, out_value, out_index, status, output ready);
endinterface

interface fca_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fca_pkg::CFG_IDX_W-1:0] index;
    logic [fca_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/fca_table_mem.sv
// ----------------------------------------------------------------------------
// fca_table_mem
// Single-port-write, single-port-read table with a registered read port and
// write-to-read forwarding for same-address accesses.
// ----------------------------------------------------------------------------
module fca_table_mem #(
    parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF,
    parameter int WORD_BITS     = fca_pkg::ENTRY_BITS_DEF + 1,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [TABLE_ENTRIES];
    logic [WORD_BITS-1:0] mem_q_reg;
    logic [WORD_BITS-1:0] fwd_data_reg;
    logic                 fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg    <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // hold a flag when the read hits the entry written in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

>>> rtl/core/fat_chain_allocator.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table of next-block links with per-entry dirty marks.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one word per command (mode, entry_index, entry_value).
//   rsp  : exactly one word per command (out_value, out_index, status).
//   cfg  : register writes, index 0 free_code, index 1 last_code; always
//          ready, write only while no command is in flight.
// Commands run one at a time through a table memory (link plus dirty bit)
// with a registered read port. Load, set, unused modes and out-of-range
// reads or frees go straight to the response; an in-range read waits for
// the table word; find free scans one entry per cycle for the free code,
// take dirty scans for a marked entry, and free chain follows one link
// per cycle up to the last code.
// The memory read port sets the pace: one entry visited per cycle.
// After reset a clearing pass writes zero to every entry, with req.ready
// low. The response sits in an output register; a new command is taken
// while that word waits. When the receiver stalls and a second result is
// finished, the block holds it until the output register frees.
// ----------------------------------------------------------------------------
module fat_chain_allocator #(
    parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF,
    parameter int ENTRY_BITS    = fca_pkg::ENTRY_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fca_req_if.sink   req,
    fca_rsp_if.source rsp,
    fca_cfg_if.sink   cfg
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int WORD_W = ENTRY_BITS + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_FIND  = 7'b0001000,
        S_TAKE  = 7'b0010000,
        S_CHAIN = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] blk_reg, blk_next;

    logic [fca_pkg::VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [fca_pkg::INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [fca_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic                         out_valid_reg, out_valid_next;
    logic [fca_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [fca_pkg::INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [fca_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic [fca_pkg::CFG_DAT_W-1:0] free_code_reg, last_code_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    // widened views for compares and narrowing
    logic [31:0]           idx32, val_in32, free32, last32, ent32, cnt32;
    logic [IDX_W-1:0]      req_idx;
    logic                  req_inside;
    logic [ENTRY_BITS-1:0] ent_val, in_val, free_val;
    logic                  ent_dirty, ent_out_range, req_fire, out_load;

    assign req_fire = req.valid && req.ready;

    assign idx32      = 32'(req.entry_index);
    assign req_idx    = idx32[IDX_W-1:0];
    assign req_inside = idx32 < 32'(TABLE_ENTRIES);
    assign val_in32   = 32'(req.entry_value);
    assign in_val     = val_in32[ENTRY_BITS-1:0];
    assign free32     = 32'(free_code_reg);
    assign free_val   = free32[ENTRY_BITS-1:0];
    assign last32     = 32'(last_code_reg);
    assign ent_val    = rd_data[ENTRY_BITS-1:0];
    assign ent_dirty  = rd_data[ENTRY_BITS];
    assign ent32      = 32'(ent_val);
    assign cnt32      = 32'(cnt_reg);
    assign ent_out_range = {1'b0, ent32} >= 33'(TABLE_ENTRIES);

    fca_table_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WORD_BITS     (WORD_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        blk_next        = blk_reg;
        res_value_next  = res_value_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[IDX_W-1:0];
        wr_data         = '0;
        rd_addr         = cnt_reg[IDX_W-1:0];
        out_load        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep zeros through the table, one entry a cycle
                wr_en = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                rd_addr = req_idx;
                if (req_fire)
                begin
                    res_value_next  = '0;
                    res_index_next  = '0;
                    res_status_next = fca_pkg::ST_OK;
                    state_next      = S_WAIT;
                    wr_addr         = req_idx;
                    unique case (req.mode)
                        fca_pkg::MODE_LOAD:
                        begin
                            wr_en   = req_inside;
                            wr_data = {1'b0, in_val};
                        end
                        fca_pkg::MODE_SET:
                        begin
                            wr_en   = req_inside;
                            wr_data = {1'b1, in_val};
                        end
                        fca_pkg::MODE_READ:
                        begin
                            if (req_inside)
                            begin
                                state_next = S_READ;
                            end
                        end
                        fca_pkg::MODE_FIND:
                        begin
                            cnt_next   = CNT_W'(1);
                            rd_addr    = IDX_W'(1);
                            state_next = S_FIND;
                        end
                        fca_pkg::MODE_FREE:
                        begin
                            if (req_inside)
                            begin
                                cnt_next   = '0;
                                blk_next   = req_idx;
                                state_next = S_CHAIN;
                            end
                            else
                            begin
                                res_status_next = fca_pkg::ST_CHAIN_ERR;
                            end
                        end
                        fca_pkg::MODE_TAKE:
                        begin
                            cnt_next   = '0;
                            rd_addr    = '0;
                            state_next = S_TAKE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_value_next = ent32[15:0];
                state_next     = S_WAIT;
            end

            S_FIND:
            begin
                priority if (ent32 == free32)
                begin
                    res_index_next = cnt32[9:0];
                    state_next     = S_WAIT;
                end
                else if (cnt_reg == CNT_LAST)
                begin
                    res_status_next = fca_pkg::ST_NO_SPACE;
                    state_next      = S_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_addr  = cnt_next[IDX_W-1:0];
                end
            end

            S_TAKE:
            begin
                priority if (ent_dirty)
                begin
                    // clear the mark, keep the link
                    wr_en          = 1'b1;
                    wr_data        = {1'b0, ent_val};
                    res_value_next = ent32[15:0];
                    res_index_next = cnt32[9:0];
                    state_next     = S_WAIT;
                end
                else if (cnt_reg == CNT_LAST)
                begin
                    res_status_next = fca_pkg::ST_NO_DIRTY;
                    state_next      = S_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_addr  = cnt_next[IDX_W-1:0];
                end
            end

            S_CHAIN:
            begin
                // cnt_reg counts links followed; blk_reg is the entry in hand
                wr_addr = blk_reg;
                wr_data = {1'b1, free_val};
                priority if (ent32 == last32)
                begin
                    wr_en      = 1'b1;
                    state_next = S_WAIT;
                end
                else if (cnt_reg == CNT_FULL)
                begin
                    res_status_next = fca_pkg::ST_CHAIN_ERR;
                    state_next      = S_WAIT;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (ent_out_range)
                    begin
                        res_status_next = fca_pkg::ST_CHAIN_ERR;
                        state_next      = S_WAIT;
                    end
                    else
                    begin
                        blk_next = ent32[IDX_W-1:0];
                        rd_addr  = ent32[IDX_W-1:0];
                    end
                end
            end

            S_WAIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: load a finished result, drop a taken word
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        priority if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            out_index_next  = res_index_reg;
            out_status_next = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            free_code_reg <= fca_pkg::FREE_CODE_RST;
            last_code_reg <= fca_pkg::LAST_CODE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    fca_pkg::REG_FREE_CODE: free_code_reg <= cfg.data;
                    fca_pkg::REG_LAST_CODE: last_code_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg        <= blk_next;
        res_value_reg  <= res_value_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.out_index = out_index_reg;
    assign rsp.status    = out_status_reg;

endmodule

>>> rtl/core/fca_checker.sv
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks of the chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fca_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [fca_pkg::VALUE_W-1:0]  out_value,
    input logic [fca_pkg::INDEX_W-1:0]  out_index,
    input logic [fca_pkg::STATUS_W-1:0] status
);

    // stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_value)
            && $stable(out_index) && $stable(status))
        else $error("response word changed under stall");

    // one command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken while another is in flight");

    // clearing pass keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !req_ready)
        else $error("request taken during clearing pass");

    // a response word only appears while a command is being finished
    a_rsp_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("unexpected response");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .out_value (rsp.out_value),
    .out_index (rsp.out_index),
    .status    (rsp.status)
);
